@@ rtl/oriented_box_overlap_test_unit_defines.svh @@
// Assertion macros shared by the oriented box overlap test RTL.
`ifndef ORIENTED_BOX_OVERLAP_TEST_UNIT_DEFINES_SVH
`define ORIENTED_BOX_OVERLAP_TEST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define OBO_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("obo assertion failed");
`define OBO_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("obo assertion failed");
`else
`define OBO_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define OBO_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/obo_pkg.sv @@
// Shared constants for the oriented box overlap test.
`timescale 1ns / 1ps
`default_nettype none

package obo_pkg;

    localparam int SIZE_BITS      = 20;
    localparam int CFG_INDEX_BITS = 3;
    localparam int OUT_TDATA_BITS = 8;
    localparam int NUM_AXES       = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COS         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIN         = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_LENGTH = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_WIDTH  = 3'd5;

endpackage

`default_nettype wire

@@ rtl/obo_proj.sv @@
// Center offset, axis products and projection sums (pipeline stages one to three).
`timescale 1ns / 1ps
`default_nettype none
`include "oriented_box_overlap_test_unit_defines.svh"

module obo_proj #(
    parameter int COORD_BITS = 28,
    parameter int HEADING_FRAC_BITS = 14,
    localparam int H = HEADING_FRAC_BITS + 2,
    localparam int S = obo_pkg::SIZE_BITS,
    localparam int D = COORD_BITS + 1,
    localparam int M = COORD_BITS + H + 1,
    localparam int P = COORD_BITS + H + 2,
    localparam int K = 2 * H + 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic signed [COORD_BITS-1:0] cand_center_x,
    input  wire logic signed [COORD_BITS-1:0] cand_center_y,
    input  wire logic signed [H-1:0]   cand_cos,
    input  wire logic signed [H-1:0]   cand_sin,
    input  wire logic [S-1:0]          cand_half_length,
    input  wire logic [S-1:0]          cand_half_width,
    input  wire logic signed [COORD_BITS-1:0] ref_center_x,
    input  wire logic signed [COORD_BITS-1:0] ref_center_y,
    input  wire logic signed [H-1:0]   ref_cos,
    input  wire logic signed [H-1:0]   ref_sin,
    output logic                       out_valid,
    output logic signed [P-1:0]        proj [obo_pkg::NUM_AXES],
    output logic signed [K-1:0]        inner,
    output logic signed [K-1:0]        outer,
    output logic [S-1:0]               cand_len,
    output logic [S-1:0]               cand_wid
);

    logic                v1_reg, v2_reg, v3_reg;
    logic signed [D-1:0] dx_next, dy_next, dx_reg, dy_reg;
    logic signed [H-1:0] c1_reg, s1_reg;
    logic [S-1:0]        hl1_reg, hw1_reg, hl2_reg, hw2_reg, hl3_reg, hw3_reg;

    logic signed [M-1:0] a_next [obo_pkg::NUM_AXES];
    logic signed [M-1:0] b_next [obo_pkg::NUM_AXES];
    logic signed [M-1:0] a_reg  [obo_pkg::NUM_AXES];
    logic signed [M-1:0] b_reg  [obo_pkg::NUM_AXES];
    logic signed [2*H-1:0] cc_next, ss_next, cs_next, sc_next;
    logic signed [2*H-1:0] cc_reg, ss_reg, cs_reg, sc_reg;

    logic signed [P-1:0] proj_next [obo_pkg::NUM_AXES];
    logic signed [P-1:0] proj_reg  [obo_pkg::NUM_AXES];
    logic signed [K-1:0] inner_next, outer_next, inner_reg, outer_reg;

    assign dx_next = D'(cand_center_x) - D'(ref_center_x);
    assign dy_next = D'(cand_center_y) - D'(ref_center_y);

    always_comb begin
        a_next[0] = M'(dx_reg) * M'(ref_cos);
        b_next[0] = M'(dy_reg) * M'(ref_sin);
        a_next[1] = M'(dx_reg) * M'(ref_sin);
        b_next[1] = M'(dy_reg) * M'(ref_cos);
        a_next[2] = M'(dx_reg) * M'(c1_reg);
        b_next[2] = M'(dy_reg) * M'(s1_reg);
        a_next[3] = M'(dx_reg) * M'(s1_reg);
        b_next[3] = M'(dy_reg) * M'(c1_reg);
        cc_next   = (2*H)'(ref_cos) * (2*H)'(c1_reg);
        ss_next   = (2*H)'(ref_sin) * (2*H)'(s1_reg);
        cs_next   = (2*H)'(ref_cos) * (2*H)'(s1_reg);
        sc_next   = (2*H)'(ref_sin) * (2*H)'(c1_reg);
    end

    always_comb begin
        proj_next[0] = P'(a_reg[0]) + P'(b_reg[0]);
        proj_next[1] = P'(a_reg[1]) - P'(b_reg[1]);
        proj_next[2] = P'(a_reg[2]) + P'(b_reg[2]);
        proj_next[3] = P'(a_reg[3]) - P'(b_reg[3]);
        inner_next   = K'(cc_reg) + K'(ss_reg);
        outer_next   = K'(cs_reg) - K'(sc_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            c1_reg     <= cand_cos;
            s1_reg     <= cand_sin;
            hl1_reg    <= cand_half_length;
            hw1_reg    <= cand_half_width;
            a_reg      <= a_next;
            b_reg      <= b_next;
            cc_reg     <= cc_next;
            ss_reg     <= ss_next;
            cs_reg     <= cs_next;
            sc_reg     <= sc_next;
            hl2_reg    <= hl1_reg;
            hw2_reg    <= hw1_reg;
            proj_reg   <= proj_next;
            inner_reg  <= inner_next;
            outer_reg  <= outer_next;
            hl3_reg    <= hl2_reg;
            hw3_reg    <= hw2_reg;
        end
    end

    assign out_valid   = v3_reg;
    assign proj        = proj_reg;
    assign inner       = inner_reg;
    assign outer       = outer_reg;
    assign cand_len    = hl3_reg;
    assign cand_wid    = hw3_reg;

    `OBO_ASSERT_NEXT(a_proj_hold, aclk, aresetn, !en && aresetn, $stable(v1_reg) && $stable(v2_reg) && $stable(v3_reg))

endmodule

`default_nettype wire

@@ rtl/obo_extent.sv @@
// Magnitudes and projected half extent products (pipeline stages four and five).
`timescale 1ns / 1ps
`default_nettype none

module obo_extent #(
    parameter int COORD_BITS = 28,
    parameter int HEADING_FRAC_BITS = 14,
    localparam int H = HEADING_FRAC_BITS + 2,
    localparam int S = obo_pkg::SIZE_BITS,
    localparam int P = COORD_BITS + H + 2,
    localparam int K = 2 * H + 1,
    localparam int L = P + HEADING_FRAC_BITS,
    localparam int E = K + S
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic signed [P-1:0] proj [obo_pkg::NUM_AXES],
    input  wire logic signed [K-1:0] inner,
    input  wire logic signed [K-1:0] outer,
    input  wire logic [S-1:0]   cand_len,
    input  wire logic [S-1:0]   cand_wid,
    input  wire logic [S-1:0]   ref_half_length,
    input  wire logic [S-1:0]   ref_half_width,
    output logic                out_valid,
    output logic [L-1:0]        lhs [obo_pkg::NUM_AXES],
    output logic [S-1:0]        own [obo_pkg::NUM_AXES],
    output logic [E-1:0]        ext_a [obo_pkg::NUM_AXES],
    output logic [E-1:0]        ext_b [obo_pkg::NUM_AXES]
);

    logic          v4_reg, v5_reg;
    logic [P-1:0]  mag_next [obo_pkg::NUM_AXES];
    logic [P-1:0]  mag_reg  [obo_pkg::NUM_AXES];
    logic [K-1:0]  inner_next, outer_next, inner_reg, outer_reg;
    logic [S-1:0]  hl_reg, hw_reg;

    logic [L-1:0]  lhs_next [obo_pkg::NUM_AXES];
    logic [L-1:0]  lhs_reg  [obo_pkg::NUM_AXES];
    logic [S-1:0]  own_next [obo_pkg::NUM_AXES];
    logic [S-1:0]  own_reg  [obo_pkg::NUM_AXES];
    logic [E-1:0]  ea_next  [obo_pkg::NUM_AXES];
    logic [E-1:0]  eb_next  [obo_pkg::NUM_AXES];
    logic [E-1:0]  ea_reg   [obo_pkg::NUM_AXES];
    logic [E-1:0]  eb_reg   [obo_pkg::NUM_AXES];

    always_comb begin
        for (int k = 0; k < obo_pkg::NUM_AXES; k++) begin
            mag_next[k] = proj[k][P-1] ? P'(-proj[k]) : P'(proj[k]);
        end
        inner_next = inner[K-1] ? K'(-inner) : K'(inner);
        outer_next = outer[K-1] ? K'(-outer) : K'(outer);
    end

    always_comb begin
        for (int k = 0; k < obo_pkg::NUM_AXES; k++) begin
            lhs_next[k] = L'(mag_reg[k]) << HEADING_FRAC_BITS;
        end
        own_next[0] = ref_half_length;
        own_next[1] = ref_half_width;
        own_next[2] = hl_reg;
        own_next[3] = hw_reg;
        ea_next[0]  = E'(inner_reg) * E'(hl_reg);
        eb_next[0]  = E'(outer_reg) * E'(hw_reg);
        ea_next[1]  = E'(outer_reg) * E'(hl_reg);
        eb_next[1]  = E'(inner_reg) * E'(hw_reg);
        ea_next[2]  = E'(inner_reg) * E'(ref_half_length);
        eb_next[2]  = E'(outer_reg) * E'(ref_half_width);
        ea_next[3]  = E'(outer_reg) * E'(ref_half_length);
        eb_next[3]  = E'(inner_reg) * E'(ref_half_width);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg   <= mag_next;
            inner_reg <= inner_next;
            outer_reg <= outer_next;
            hl_reg    <= cand_len;
            hw_reg    <= cand_wid;
            lhs_reg   <= lhs_next;
            own_reg   <= own_next;
            ea_reg    <= ea_next;
            eb_reg    <= eb_next;
        end
    end

    assign out_valid = v5_reg;
    assign lhs       = lhs_reg;
    assign own       = own_reg;
    assign ext_a     = ea_reg;
    assign ext_b     = eb_reg;

endmodule

`default_nettype wire

@@ rtl/obo_cmp.sv @@
// Right-hand side sums and per-axis compare (pipeline stages six and seven).
`timescale 1ns / 1ps
`default_nettype none

module obo_cmp #(
    parameter int COORD_BITS = 28,
    parameter int HEADING_FRAC_BITS = 14,
    localparam int H  = HEADING_FRAC_BITS + 2,
    localparam int S  = obo_pkg::SIZE_BITS,
    localparam int P  = COORD_BITS + H + 2,
    localparam int L  = P + HEADING_FRAC_BITS,
    localparam int E  = 2 * H + 1 + S,
    localparam int R0 = (S + 2 * HEADING_FRAC_BITS > E) ? S + 2 * HEADING_FRAC_BITS : E,
    localparam int R  = R0 + 2,
    localparam int W  = (L > R) ? L : R
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         en,
    input  wire logic         in_valid,
    input  wire logic [L-1:0] lhs [obo_pkg::NUM_AXES],
    input  wire logic [S-1:0] own [obo_pkg::NUM_AXES],
    input  wire logic [E-1:0] ext_a [obo_pkg::NUM_AXES],
    input  wire logic [E-1:0] ext_b [obo_pkg::NUM_AXES],
    output logic              out_valid,
    output logic              overlap
);

    logic                          v6_reg, v7_reg;
    logic [W-1:0]                  lhs_reg  [obo_pkg::NUM_AXES];
    logic [W-1:0]                  rhs_next [obo_pkg::NUM_AXES];
    logic [W-1:0]                  rhs_reg  [obo_pkg::NUM_AXES];
    logic [obo_pkg::NUM_AXES-1:0]  pass;
    logic                          overlap_next, overlap_reg;

    always_comb begin
        for (int k = 0; k < obo_pkg::NUM_AXES; k++) begin
            rhs_next[k] = (W'(own[k]) << (2 * HEADING_FRAC_BITS)) + W'(ext_a[k]) + W'(ext_b[k]);
        end
    end

    always_comb begin
        for (int k = 0; k < obo_pkg::NUM_AXES; k++) begin
            pass[k] = (lhs_reg[k] <= rhs_reg[k]);
        end
        overlap_next = &pass;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= in_valid;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < obo_pkg::NUM_AXES; k++) begin
                lhs_reg[k] <= W'(lhs[k]);
            end
            rhs_reg     <= rhs_next;
            overlap_reg <= overlap_next;
        end
    end

    assign out_valid = v7_reg;
    assign overlap   = overlap_reg;

endmodule

`default_nettype wire

@@ rtl/oriented_box_overlap_test_unit.sv @@
// Top level of the oriented box overlap test: stream ports, configuration and pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "oriented_box_overlap_test_unit_defines.svh"

// Separating axis overlap test of a candidate oriented rectangle against a reference
// rectangle held in six write-only registers. One transaction enters per clock unless the
// result side stalls: the path is a seven-stage pipeline (offset, axis multiplies,
// projection sums, magnitudes, extent multiplies, bound sums, compare) whose
// last stage is the output register. All stages advance together whenever the output
// register is empty or being taken, so a stall on the result side holds every stage and
// backpressures the input. overlap is 1 when the boxes touch or overlap on all four axes.
// Write the reference registers only while the pipeline is empty.

module oriented_box_overlap_test_unit #(
    parameter int COORD_BITS = 28,
    parameter int HEADING_FRAC_BITS = 14,
    localparam int H  = HEADING_FRAC_BITS + 2,
    localparam int S  = obo_pkg::SIZE_BITS,
    localparam int IN_BITS   = 2 * COORD_BITS + 2 * H + 2 * S,
    localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8,
    localparam int CW0 = (COORD_BITS > H) ? COORD_BITS : H,
    localparam int CFG_DATA  = (CW0 > S) ? CW0 : S,
    localparam int P  = COORD_BITS + H + 2,
    localparam int K  = 2 * H + 1,
    localparam int L  = P + HEADING_FRAC_BITS,
    localparam int E  = K + S
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // cand_center_x, cand_center_y, cand_cos, cand_sin, cand_half_length, cand_half_width
    input  wire logic [IN_TDATA-1:0]               s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // overlap
    output logic [obo_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [obo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA-1:0]               cfg_wdata
);

    localparam int CY_LO = COORD_BITS;
    localparam int CC_LO = 2 * COORD_BITS;
    localparam int CS_LO = CC_LO + H;
    localparam int HL_LO = CS_LO + H;
    localparam int HW_LO = HL_LO + S;

    logic signed [COORD_BITS-1:0] ref_center_x_reg, ref_center_y_reg;
    logic signed [H-1:0]          ref_cos_reg, ref_sin_reg;
    logic [S-1:0]                 ref_half_length_reg, ref_half_width_reg;

    logic                   en;
    logic                   proj_valid, ext_valid, overlap;
    logic signed [P-1:0]    proj [obo_pkg::NUM_AXES];
    logic signed [K-1:0]    inner, outer;
    logic [S-1:0]           cand_len, cand_wid;
    logic [L-1:0]           lhs [obo_pkg::NUM_AXES];
    logic [S-1:0]           own [obo_pkg::NUM_AXES];
    logic [E-1:0]           ext_a [obo_pkg::NUM_AXES];
    logic [E-1:0]           ext_b [obo_pkg::NUM_AXES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_center_x_reg    <= '0;
            ref_center_y_reg    <= '0;
            ref_cos_reg         <= H'(1) << HEADING_FRAC_BITS;
            ref_sin_reg         <= '0;
            ref_half_length_reg <= '0;
            ref_half_width_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                obo_pkg::REG_CENTER_X:    ref_center_x_reg    <= cfg_wdata[COORD_BITS-1:0];
                obo_pkg::REG_CENTER_Y:    ref_center_y_reg    <= cfg_wdata[COORD_BITS-1:0];
                obo_pkg::REG_COS:         ref_cos_reg         <= cfg_wdata[H-1:0];
                obo_pkg::REG_SIN:         ref_sin_reg         <= cfg_wdata[H-1:0];
                obo_pkg::REG_HALF_LENGTH: ref_half_length_reg <= cfg_wdata[S-1:0];
                obo_pkg::REG_HALF_WIDTH:  ref_half_width_reg  <= cfg_wdata[S-1:0];
                default: ;
            endcase
        end
    end

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    obo_proj #(
        .COORD_BITS        (COORD_BITS),
        .HEADING_FRAC_BITS (HEADING_FRAC_BITS)
    ) u_proj (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (en),
        .in_valid         (s_axis_tvalid),
        .cand_center_x    (s_axis_tdata[CY_LO-1:0]),
        .cand_center_y    (s_axis_tdata[CC_LO-1:CY_LO]),
        .cand_cos         (s_axis_tdata[CS_LO-1:CC_LO]),
        .cand_sin         (s_axis_tdata[HL_LO-1:CS_LO]),
        .cand_half_length (s_axis_tdata[HW_LO-1:HL_LO]),
        .cand_half_width  (s_axis_tdata[HW_LO+S-1:HW_LO]),
        .ref_center_x     (ref_center_x_reg),
        .ref_center_y     (ref_center_y_reg),
        .ref_cos          (ref_cos_reg),
        .ref_sin          (ref_sin_reg),
        .out_valid        (proj_valid),
        .proj             (proj),
        .inner            (inner),
        .outer            (outer),
        .cand_len         (cand_len),
        .cand_wid         (cand_wid)
    );

    obo_extent #(
        .COORD_BITS        (COORD_BITS),
        .HEADING_FRAC_BITS (HEADING_FRAC_BITS)
    ) u_extent (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (en),
        .in_valid        (proj_valid),
        .proj            (proj),
        .inner           (inner),
        .outer           (outer),
        .cand_len        (cand_len),
        .cand_wid        (cand_wid),
        .ref_half_length (ref_half_length_reg),
        .ref_half_width  (ref_half_width_reg),
        .out_valid       (ext_valid),
        .lhs             (lhs),
        .own             (own),
        .ext_a           (ext_a),
        .ext_b           (ext_b)
    );

    obo_cmp #(
        .COORD_BITS        (COORD_BITS),
        .HEADING_FRAC_BITS (HEADING_FRAC_BITS)
    ) u_cmp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ext_valid),
        .lhs       (lhs),
        .own       (own),
        .ext_a     (ext_a),
        .ext_b     (ext_b),
        .out_valid (m_axis_tvalid),
        .overlap   (overlap)
    );

    assign m_axis_tdata = {{(obo_pkg::OUT_TDATA_BITS-1){1'b0}}, overlap};

    `OBO_ASSERT_NEXT(a_cfg_cos, aclk, aresetn, cfg_we && cfg_index == obo_pkg::REG_COS, ref_cos_reg == $past(cfg_wdata[H-1:0]))
    `OBO_ASSERT_IMPL(a_stall_blocks, aclk, aresetn, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `OBO_ASSERT_IMPL(a_empty_takes, aclk, aresetn, !m_axis_tvalid, s_axis_tready)

endmodule

`default_nettype wire
